// ===== hw/rtl/psu_pkg.sv =====
`timescale 1ns / 1ps

package psu_pkg;

   // Line buffer geometry
   localparam int MAX_ROW_BYTES = 16384;
   localparam int COL_W         = $clog2(MAX_ROW_BYTES);
   localparam int RB_W          = $clog2(MAX_ROW_BYTES + 1);

   // Configuration field widths
   localparam int BPP_W       = 3;
   localparam int PX_W        = 13;
   localparam int CSR_DATA_W  = 13;

   // Register indexes
   typedef enum logic [0:0] {
      CSR_BPP        = 1'b0,
      CSR_ROW_PIXELS = 1'b1
   } csr_index_type;

   // Scanline filter types; FILTER_BAD marks an unknown type (acts as None)
   typedef enum logic [2:0] {
      FILTER_NONE  = 3'd0,
      FILTER_SUB   = 3'd1,
      FILTER_UP    = 3'd2,
      FILTER_AVG   = 3'd3,
      FILTER_PAETH = 3'd4,
      FILTER_BAD   = 3'd5
   } filter_type;

   // One data byte handed from the control stage to reconstruction
   typedef struct packed {
      logic             valid;
      logic [7:0]       data;
      logic [COL_W-1:0] col;
      logic             first_row;
      filter_type       filter;
      logic [1:0]       chan;
      logic             last;
      logic             left_ok;
      logic             bpp4;
   } issue_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
   } lb_read_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
      logic [7:0]       data;
   } lb_write_type;

endpackage

// ===== hw/rtl/psu_stream_if.sv =====
`timescale 1ns / 1ps

// Input byte stream channel
interface psu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   logic       image_start;

   modport source (output valid, output stream_byte, output image_start, input ready);
   modport sink   (input valid, input stream_byte, input image_start, output ready);
endinterface

// Reconstructed byte channel
interface psu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_byte;
   logic [1:0] channel_index;
   logic       row_end;
   logic       bad_filter;

   modport source (output valid, output pixel_byte, output channel_index,
                   output row_end, output bad_filter, input ready);
   modport sink   (input valid, input pixel_byte, input channel_index,
                   input row_end, input bad_filter, output ready);
endinterface

// ===== hw/rtl/png_scanline_unfilter_unit.sv =====
`timescale 1ns / 1ps
// A data byte is loaded into stage one as it is taken and moves to the output
// register when stage one advances; rsp offers it from that register.
// Throughput: one stream byte per cycle while the output is not stalled; filter bytes give no result.
// The line buffer read is issued as the byte is taken; reconstruction and
// write-back happen together as stage one advances, with forwarding on a same-entry access.
// Reset (synchronous, active high) clears control and config; line buffer is not cleared.
module png_scanline_unfilter_unit
   import psu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   psu_req_if.sink               req_if,
   psu_rsp_if.source             rsp_if,
   input  logic                  csr_write_en,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   issue_type    issue;
   lb_read_type  lb_rd;
   lb_write_type lb_wr;
   logic [7:0]   rd_data;
   logic         take;

   psu_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req          (req_if),
      .take         (take),
      .issue        (issue),
      .lb_rd        (lb_rd)
   );

   psu_line_buf u_line_buf (
      .clock   (clock),
      .rd      (lb_rd),
      .wr      (lb_wr),
      .rd_data (rd_data)
   );

   psu_recon u_recon (
      .clock   (clock),
      .reset   (reset),
      .issue   (issue),
      .rd_data (rd_data),
      .take    (take),
      .lb_wr   (lb_wr),
      .rsp     (rsp_if)
   );

endmodule

// ===== hw/rtl/psu_line_buf.sv =====
`timescale 1ns / 1ps

// Previous-row byte store: one write and one registered read per cycle
module psu_line_buf
   import psu_pkg::*;
(
   input  logic         clock,
   input  lb_read_type  rd,
   input  lb_write_type wr,
   output logic [7:0]   rd_data
);

   logic [7:0] mem [MAX_ROW_BYTES];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data <= mem[rd.addr];
      end
   end

endmodule

// ===== hw/rtl/psu_ctrl.sv =====
`timescale 1ns / 1ps

// Row sequencing: filter byte capture, column count, line buffer read issue
module psu_ctrl
   import psu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   psu_req_if.sink               req,
   input  logic                  take,
   output issue_type             issue,
   output lb_read_type           lb_rd
);

   localparam int MOD3_SHIFT = COL_W + 2;
   localparam int MOD3_PROD_W = COL_W + MOD3_SHIFT;
   localparam logic [MOD3_SHIFT-1:0] MOD3_RECIP = MOD3_SHIFT'((1 << MOD3_SHIFT) / 3 + 1);
   localparam int PROD_W = PX_W + 2;

   logic [BPP_W-1:0] bpp_ff, bpp_in;
   logic [PX_W-1:0]  px_ff, px_in;
   logic [COL_W-1:0] column_ff, column_in;
   filter_type       filter_ff, filter_in;
   logic             first_row_ff, first_row_in;
   logic             expect_ff, expect_in;

   logic                   accept;
   logic                   bpp4;
   logic [PX_W-1:0]        px_used;
   logic [PROD_W-1:0]      row_prod;
   logic [RB_W-1:0]        row_bytes;
   logic                   first_row_eff;
   logic                   expect_eff;
   logic [COL_W-1:0]       column_eff;
   logic [COL_W-1:0]       col;
   logic                   last;
   logic [MOD3_PROD_W-1:0] mod3_prod;
   logic [COL_W-1:0]       mod3_quot;
   logic [COL_W-1:0]       mod3_rem;
   logic [1:0]             chan;

   assign accept    = req.valid && take;
   assign req.ready = take;

   // Row length in bytes, saturated at the line buffer depth
   assign bpp4     = (bpp_ff == BPP_W'(4));
   assign px_used  = (px_ff == '0) ? PX_W'(1) : px_ff;
   assign row_prod = bpp4 ? {px_used, 2'b00}
                          : PROD_W'({1'b0, px_used, 1'b0}) + PROD_W'(px_used);
   assign row_bytes = (int'(row_prod) > MAX_ROW_BYTES) ? RB_W'(MAX_ROW_BYTES)
                                                       : RB_W'(row_prod);

   // A new image forces a filter byte and restarts the row count
   assign first_row_eff = req.image_start ? 1'b1 : first_row_ff;
   assign expect_eff    = req.image_start ? 1'b1 : expect_ff;
   assign column_eff    = req.image_start ? '0   : column_ff;

   assign col  = (int'(column_eff) >= MAX_ROW_BYTES) ? COL_W'(MAX_ROW_BYTES - 1) : column_eff;
   assign last = (int'(column_eff) + 1) >= int'(row_bytes);

   // col mod 3 by reciprocal multiply; mod 4 is the low bits
   assign mod3_prod = MOD3_PROD_W'(col) * MOD3_PROD_W'(MOD3_RECIP);
   assign mod3_quot = mod3_prod[MOD3_SHIFT +: COL_W];
   assign mod3_rem  = col - COL_W'(3 * int'(mod3_quot));
   assign chan      = bpp4 ? col[1:0] : mod3_rem[1:0];

   // Next control state
   always_comb begin
      bpp_in       = bpp_ff;
      px_in        = px_ff;
      column_in    = column_ff;
      filter_in    = filter_ff;
      first_row_in = first_row_ff;
      expect_in    = expect_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_BPP:        bpp_in = csr_data[BPP_W-1:0];
            CSR_ROW_PIXELS: px_in  = csr_data[PX_W-1:0];
            default:        ;
         endcase
      end
      if (accept) begin
         if (expect_eff) begin
            filter_in    = (req.stream_byte > 8'd4) ? FILTER_BAD
                                                    : filter_type'(req.stream_byte[2:0]);
            expect_in    = 1'b0;
            column_in    = '0;
            first_row_in = first_row_eff;
         end else if (last) begin
            column_in    = '0;
            expect_in    = 1'b1;
            first_row_in = 1'b0;
         end else begin
            column_in    = column_eff + COL_W'(1);
            first_row_in = first_row_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff       <= BPP_W'(3);
         px_ff        <= PX_W'(1);
         column_ff    <= '0;
         filter_ff    <= FILTER_NONE;
         first_row_ff <= 1'b1;
         expect_ff    <= 1'b1;
      end else begin
         bpp_ff       <= bpp_in;
         px_ff        <= px_in;
         column_ff    <= column_in;
         filter_ff    <= filter_in;
         first_row_ff <= first_row_in;
         expect_ff    <= expect_in;
      end
   end

   // Data byte issue and line buffer read, one byte ahead of reconstruction
   always_comb begin
      issue.valid     = req.valid && !expect_eff;
      issue.data      = req.stream_byte;
      issue.col       = col;
      issue.first_row = first_row_eff;
      issue.filter    = filter_ff;
      issue.chan      = chan;
      issue.last      = last;
      issue.left_ok   = bpp4 ? (int'(col) >= 4) : (int'(col) >= 3);
      issue.bpp4      = bpp4;
      lb_rd.en        = accept && !expect_eff;
      lb_rd.addr      = col;
   end

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      int'(column_ff) < MAX_ROW_BYTES)
      else $error("column count beyond line buffer");

   a_last_expects_filter: assert property (@(posedge clock) disable iff (reset)
      (accept && issue.valid && issue.last) |=> expect_ff)
      else $error("row end did not arm filter byte");

   a_filter_no_issue: assert property (@(posedge clock) disable iff (reset)
      (accept && expect_eff) |-> !lb_rd.en)
      else $error("filter byte issued a line buffer read");

endmodule

// ===== hw/rtl/psu_recon.sv =====
`timescale 1ns / 1ps

// Byte reconstruction, line buffer write-back and output register
module psu_recon
   import psu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  issue_type    issue,
   input  logic [7:0]   rd_data,
   output logic         take,
   output lb_write_type lb_wr,
   psu_rsp_if.source    rsp
);

   function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
      logic signed [9:0] pa;
      logic signed [9:0] pb;
      logic signed [9:0] pc;
      logic signed [9:0] sa;
      logic signed [9:0] sb;
      logic signed [9:0] sc;
      sa = $signed({2'b00, a});
      sb = $signed({2'b00, b});
      sc = $signed({2'b00, c});
      pa = sb - sc;
      pb = sa - sc;
      pc = sa + sb - sc - sc;
      pa = (pa < 0) ? -pa : pa;
      pb = (pb < 0) ? -pb : pb;
      pc = (pc < 0) ? -pc : pc;
      if (pa <= pb && pa <= pc) begin
         return a;
      end else if (pb <= pc) begin
         return b;
      end
      return c;
   endfunction

   logic             s1_valid_ff, s1_valid_in;
   issue_type        s1_ff;
   logic             fwd_ff, fwd_in;
   logic [7:0]       fwd_data_ff;
   logic [31:0]      left_ff;
   logic [31:0]      upper_left_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       pixel_ff;
   logic [1:0]       chan_ff;
   logic             row_end_ff;
   logic             bad_ff;

   logic             out_free;
   logic             advance;
   logic             load;
   logic [7:0]       a;
   logic [7:0]       b;
   logic [7:0]       c;
   logic [8:0]       avg_sum;
   logic [7:0]       pred;
   logic [7:0]       res;

   // Stage one moves when the output register is free or being drained
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign advance  = s1_valid_ff && out_free;
   assign take     = !s1_valid_ff || out_free;
   assign load     = issue.valid && take;

   // Neighbors: left and upper-left are one pixel back in the shift registers
   always_comb begin
      a = '0;
      c = '0;
      if (s1_ff.left_ok) begin
         a = s1_ff.bpp4 ? left_ff[31:24] : left_ff[23:16];
      end
      if (s1_ff.left_ok && !s1_ff.first_row) begin
         c = s1_ff.bpp4 ? upper_left_ff[31:24] : upper_left_ff[23:16];
      end
      b = '0;
      if (!s1_ff.first_row) begin
         b = fwd_ff ? fwd_data_ff : rd_data;
      end
   end

   // Predictor select
   assign avg_sum = {1'b0, a} + {1'b0, b};
   always_comb begin
      case (s1_ff.filter)
         FILTER_SUB:   pred = a;
         FILTER_UP:    pred = b;
         FILTER_AVG:   pred = avg_sum[8:1];
         FILTER_PAETH: pred = paeth(a, b, c);
         default:      pred = '0;
      endcase
   end
   assign res = s1_ff.data + pred;

   // Write back the reconstructed byte as this row's entry
   assign lb_wr.en   = advance;
   assign lb_wr.addr = s1_ff.col;
   assign lb_wr.data = res;

   // Forward when a read issues to the entry being written this cycle
   assign fwd_in = lb_wr.en && (lb_wr.addr == issue.col);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take) begin
         s1_valid_in = issue.valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            fwd_ff <= fwd_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (load) begin
         s1_ff       <= issue;
         fwd_data_ff <= res;
      end
      if (advance) begin
         left_ff       <= {left_ff[23:0], res};
         upper_left_ff <= {upper_left_ff[23:0], b};
         pixel_ff      <= res;
         chan_ff       <= s1_ff.chan;
         row_end_ff    <= s1_ff.last;
         bad_ff        <= (s1_ff.filter == FILTER_BAD);
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.pixel_byte    = pixel_ff;
   assign rsp.channel_index = chan_ff;
   assign rsp.row_end       = row_end_ff;
   assign rsp.bad_filter    = bad_ff;

   a_fwd_after_write: assert property (@(posedge clock) disable iff (reset)
      $rose(fwd_ff) |-> $past(lb_wr.en))
      else $error("forward flag set without a write");

   a_write_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> !lb_wr.en)
      else $error("line buffer written with empty stage");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> s1_valid_ff)
      else $error("stalled byte dropped from stage one");

endmodule
